/* sv/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* sv/gdcp_pkg.sv */
package gdcp_pkg;

    localparam int unsigned IN_W  = 32;
    localparam int unsigned OUT_W = 80;

    typedef enum logic [7:0] {
        OP_RESET    = 8'h00,
        OP_ENABLE   = 8'h03,
        OP_POSITION = 8'h05,
        OP_HRANGE   = 8'h06,
        OP_VRANGE   = 8'h07,
        OP_MODE     = 8'h08
    } op_t;

    localparam logic [9:0]  MODE_W_RESET  = 10'd320;
    localparam logic [12:0] MODE_H_RESET  = 13'd240;
    localparam logic [9:0]  START_X_MAX   = 10'd1000;
    localparam logic [10:0] HSTART_BIAS   = 11'd500;
    localparam logic [9:0]  GUARD_PAL     = 10'd48;
    localparam logic [9:0]  GUARD_NTSC    = 10'd28;
    localparam logic [9:0]  GUARD_MARGIN  = 10'd4;
    // divide by 2560 = shift by 9, then multiply by ceil(2^16 / 5)
    localparam logic [13:0] DIV5_RECIP    = 14'd13108;
    localparam logic [1:0]  IL_TEST_START = 2'd2;

    // Packed from frame_update (MSB) down to start_x (LSB).
    typedef struct packed {
        logic               frame_update;
        logic               geometry_changed;
        logic               interlaced;
        logic               true_color;
        logic               disabled;
        logic [10:0]        top_offset;
        logic signed [11:0] visible_width;
        logic [9:0]         left_offset;
        logic signed [12:0] height;
        logic [9:0]         width;
        logic [8:0]         start_y;
        logic [9:0]         start_x;
    } res_t;

    typedef struct packed {
        logic [10:0]        x0;
        logic signed [11:0] x1;
        logic               moved;
    } cx_t;

    function automatic logic [9:0] mode_width(input logic [2:0] sel);
        logic [9:0] w;
        case (sel)
            3'd0:    w = 10'd256;
            3'd1:    w = 10'd320;
            3'd2:    w = 10'd512;
            3'd3:    w = 10'd640;
            3'd4:    w = 10'd368;
            3'd5:    w = 10'd384;
            3'd6:    w = 10'd512;
            default: w = 10'd640;
        endcase
        return w;
    endfunction

endpackage

/* sv/gdcp_center_x.sv */
module gdcp_center_x (
    input  logic [9:0]         mode_w,
    input  logic signed [12:0] span,
    input  logic [10:0]        start_x,
    input  logic [10:0]        x0_cur,
    input  logic signed [11:0] x1_cur,
    output gdcp_pkg::cx_t      cx
);

    logic signed [23:0] prod;
    logic [22:0]        mag;
    logic [13:0]        coarse;
    logic [27:0]        recip;
    logic [9:0]         quot;
    logic signed [11:0] scaled;
    logic signed [11:0] aligned;
    logic [10:0]        x0_base;
    logic signed [12:0] fit_sum;
    logic signed [11:0] wrap;

    assign prod    = $signed({1'b0, mode_w}) * span;
    assign mag     = prod[23] ? 23'(-prod) : prod[22:0];
    assign coarse  = mag[22:9];
    assign recip   = coarse * gdcp_pkg::DIV5_RECIP;
    assign quot    = recip[25:16];
    // truncate toward zero
    assign scaled  = prod[23] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    // floor to a multiple of 8, toward minus infinity
    assign aligned = {scaled[11:3], 3'b000};
    assign x0_base = (start_x > gdcp_pkg::HSTART_BIAS) ?
                     ((start_x - gdcp_pkg::HSTART_BIAS) >> 3) : 11'd0;
    assign fit_sum = $signed({2'b00, x0_base}) + $signed({scaled[11], scaled});
    assign wrap    = $signed({2'b00, mode_w}) - scaled;

    always_comb
    begin
        cx.x0    = x0_cur;
        cx.x1    = x1_cur;
        cx.moved = 1'b0;
        if (span != 13'sd0 && aligned != x1_cur)
        begin
            if (scaled >= $signed({2'b00, mode_w}))
            begin
                cx.x1 = $signed({2'b00, mode_w});
                cx.x0 = 11'd0;
            end
            else
            begin
                cx.x1 = aligned;
                cx.x0 = x0_base;
                if (fit_sum > $signed({3'b000, mode_w}))
                begin
                    cx.x0 = wrap[10:0];
                    cx.x1 = scaled;
                end
            end
            cx.moved = (cx.x0 != x0_cur);
        end
    end

endmodule

/* sv/gdcp_core.sv */
module gdcp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [31:0]         word,
    input  logic                swap_fix,
    output gdcp_pkg::res_t      res_next
);

    logic               disabled_reg, disabled_next;
    logic [9:0]         cur_x_reg, cur_x_next;
    logic [8:0]         cur_y_reg, cur_y_next;
    logic [9:0]         prev_x_reg, prev_x_next;
    logic [8:0]         prev_y_reg, prev_y_next;
    logic [9:0]         mode_w_reg, mode_w_next;
    logic signed [12:0] mode_h_reg, mode_h_next;
    logic [9:0]         new_mode_w_reg, new_mode_w_next;
    logic signed [12:0] new_mode_h_reg, new_mode_h_next;
    logic signed [9:0]  neg_adj_reg, neg_adj_next;
    logic [10:0]        rsx_reg, rsx_next;
    logic signed [12:0] span_reg, span_next;
    logic [9:0]         rsy_reg, rsy_next;
    logic signed [11:0] line_h_reg, line_h_next;
    logic [10:0]        x0_reg, x0_next;
    logic signed [11:0] x1_reg, x1_next;
    logic [10:0]        y0_reg, y0_next;
    logic               dbl_reg, dbl_next;
    logic               pal_reg, pal_next;
    logic [1:0]         rgb_reg, rgb_next;
    logic [1:0]         il_reg, il_next;
    logic [1:0]         il_test_reg, il_test_next;

    gdcp_pkg::op_t      op;
    gdcp_pkg::cx_t      cx;
    logic [9:0]         cx_mode_w;
    logic signed [12:0] cx_span;
    logic [10:0]        cx_start_x;
    logic signed [12:0] span_new;
    logic [9:0]         table_w;

    logic [9:0]         sx;
    logic [8:0]         sy;
    logic signed [10:0] neg_half;
    logic               same;
    logic [9:0]         vr_start;
    logic [9:0]         vr_end;
    logic signed [11:0] lh;
    logic signed [11:0] lh_src;
    logic               lh_dbl;
    logic signed [12:0] nmh;
    logic [9:0]         nmw;
    logic [10:0]        off;
    logic               apply_req;
    logic [1:0]         rgb_n;
    logic [1:0]         il_n;
    logic               rgb_diff;
    logic               il_diff;
    logic               geo;
    logic               frame;

    function automatic logic [10:0] calc_off(input logic [9:0] rsy, input logic pal,
                                             input logic dbl);
        logic [9:0]  floor_v;
        logic [9:0]  diff;
        logic [10:0] r;
        floor_v = (pal ? gdcp_pkg::GUARD_PAL : gdcp_pkg::GUARD_NTSC) + gdcp_pkg::GUARD_MARGIN;
        diff    = rsy - floor_v;
        r       = 11'd0;
        if (rsy > floor_v)
        begin
            r = dbl ? {diff, 1'b0} : {1'b0, diff};
        end
        return r;
    endfunction

    assign op         = gdcp_pkg::op_t'(word[31:24]);
    assign table_w    = gdcp_pkg::mode_width({word[6], word[1:0]});
    assign span_new   = $signed({1'b0, word[23:12]}) - $signed({2'b00, word[10:0]});
    assign cx_mode_w  = (op == gdcp_pkg::OP_HRANGE) ? mode_w_reg :
                        (op == gdcp_pkg::OP_MODE)   ? table_w : new_mode_w_reg;
    assign cx_span    = (op == gdcp_pkg::OP_HRANGE) ? span_new : span_reg;
    assign cx_start_x = (op == gdcp_pkg::OP_HRANGE) ? word[10:0] : rsx_reg;

    gdcp_center_x u_center_x (
        .mode_w  (cx_mode_w),
        .span    (cx_span),
        .start_x (cx_start_x),
        .x0_cur  (x0_reg),
        .x1_cur  (x1_reg),
        .cx      (cx)
    );

    always_comb
    begin
        disabled_next   = disabled_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        mode_w_next     = mode_w_reg;
        mode_h_next     = mode_h_reg;
        new_mode_w_next = new_mode_w_reg;
        new_mode_h_next = new_mode_h_reg;
        neg_adj_next    = neg_adj_reg;
        rsx_next        = rsx_reg;
        span_next       = span_reg;
        rsy_next        = rsy_reg;
        line_h_next     = line_h_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y0_next         = y0_reg;
        dbl_next        = dbl_reg;
        pal_next        = pal_reg;
        rgb_next        = rgb_reg;
        il_next         = il_reg;
        il_test_next    = il_test_reg;
        geo             = 1'b0;
        frame           = 1'b0;
        apply_req       = 1'b0;
        rgb_n           = rgb_reg;
        il_n            = il_reg;
        nmw             = new_mode_w_reg;
        sx              = word[9:0];
        sy              = word[18:10];
        neg_half        = $signed({word[19], word[19:10]}) + 11'sd1;
        same            = 1'b0;
        vr_start        = word[9:0];
        vr_end          = word[19:10];
        lh              = $signed({2'b00, vr_end}) - $signed({2'b00, vr_start})
                          + $signed({{2{neg_adj_reg[9]}}, neg_adj_reg});
        lh_src          = (op == gdcp_pkg::OP_MODE) ? line_h_reg : lh;
        lh_dbl          = (op == gdcp_pkg::OP_MODE) ? word[2] : dbl_reg;
        off             = (op == gdcp_pkg::OP_MODE) ? calc_off(rsy_reg, pal_reg, word[2])
                                                    : calc_off(vr_start, pal_reg, dbl_reg);
        nmh             = (lh_dbl ? {lh_src, 1'b0} : {lh_src[11], lh_src})
                          + $signed({2'b00, off});
        rgb_diff        = 1'b0;
        il_diff         = 1'b0;

        if (fire)
        begin
            case (op)
                gdcp_pkg::OP_RESET:
                begin
                    disabled_next = 1'b1;
                    rgb_next[0]   = 1'b0;
                    il_next[0]    = 1'b0;
                end
                gdcp_pkg::OP_ENABLE:
                begin
                    disabled_next = word[0];
                end
                gdcp_pkg::OP_POSITION:
                begin
                    if (word[19])
                    begin
                        neg_adj_next = dbl_reg ? neg_half[10:1] : $signed(word[19:10]);
                        sy           = 9'd0;
                    end
                    else
                    begin
                        neg_adj_next = 10'sd0;
                    end
                    if (sx > gdcp_pkg::START_X_MAX)
                    begin
                        sx = 10'd0;
                    end
                    if (swap_fix)
                    begin
                        same = !il_reg[0] && prev_x_reg == sx && prev_y_reg == sy;
                        if (!same)
                        begin
                            cur_x_next  = prev_x_reg;
                            cur_y_next  = prev_y_reg;
                            prev_x_next = sx;
                            prev_y_next = sy;
                        end
                    end
                    else
                    begin
                        same = !il_reg[0] && cur_x_reg == sx && cur_y_reg == sy;
                        if (!same)
                        begin
                            prev_x_next = cur_x_reg;
                            prev_y_next = cur_y_reg;
                            cur_x_next  = sx;
                            cur_y_next  = sy;
                        end
                    end
                    if (!same)
                    begin
                        geo = 1'b1;
                        if (!il_reg[0])
                        begin
                            frame = 1'b1;
                        end
                        else if (il_test_reg != 2'd0 &&
                                 (prev_x_next != cur_x_next || prev_y_next != cur_y_next))
                        begin
                            il_test_next = il_test_reg - 2'd1;
                        end
                    end
                end
                gdcp_pkg::OP_HRANGE:
                begin
                    rsx_next  = word[10:0];
                    span_next = span_new;
                    x0_next   = cx.x0;
                    x1_next   = cx.x1;
                    geo       = cx.moved;
                end
                gdcp_pkg::OP_VRANGE:
                begin
                    rsy_next    = vr_start;
                    line_h_next = lh;
                    if (lh != line_h_reg)
                    begin
                        new_mode_h_next = nmh;
                        if ({1'b0, off} != {1'b0, y0_reg})
                        begin
                            y0_next = off;
                            geo     = 1'b1;
                        end
                        apply_req = 1'b1;
                    end
                end
                gdcp_pkg::OP_MODE:
                begin
                    nmw             = table_w;
                    new_mode_w_next = table_w;
                    dbl_next        = word[2];
                    new_mode_h_next = nmh;
                    if (off != y0_reg)
                    begin
                        y0_next = off;
                        geo     = 1'b1;
                    end
                    pal_next = word[3];
                    rgb_n    = {word[4], rgb_reg[0]};
                    il_n     = {word[5], il_reg[0]};
                    rgb_next = rgb_n;
                    il_next  = il_n;
                    if (word[5])
                    begin
                        if (!il_reg[0])
                        begin
                            il_test_next = gdcp_pkg::IL_TEST_START;
                            prev_x_next  = cur_x_reg;
                            prev_y_next  = cur_y_reg;
                        end
                    end
                    else
                    begin
                        il_test_next = 2'd0;
                    end
                    apply_req = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (apply_req)
            begin
                rgb_diff = rgb_n[0] ^ rgb_n[1];
                il_diff  = il_n[0] ^ il_n[1];
                if (mode_h_reg != nmh || mode_w_reg != nmw || rgb_diff || il_diff)
                begin
                    geo         = 1'b1;
                    rgb_next[0] = rgb_n[1];
                    il_next[0]  = il_n[1];
                    mode_h_next = nmh;
                    mode_w_next = nmw;
                    x0_next     = cx.x0;
                    x1_next     = cx.x1;
                    if (rgb_diff)
                    begin
                        frame = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res_next.frame_update     = frame;
        res_next.geometry_changed = geo;
        res_next.interlaced       = il_next[0];
        res_next.true_color       = rgb_next[0];
        res_next.disabled         = disabled_next;
        res_next.top_offset       = y0_next;
        res_next.visible_width    = x1_next;
        res_next.left_offset      = x0_next[9:0];
        res_next.height           = mode_h_next;
        res_next.width            = mode_w_next;
        res_next.start_y          = cur_y_next;
        res_next.start_x          = cur_x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg   <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            mode_w_reg     <= gdcp_pkg::MODE_W_RESET;
            mode_h_reg     <= gdcp_pkg::MODE_H_RESET;
            new_mode_w_reg <= '0;
            new_mode_h_reg <= '0;
            neg_adj_reg    <= '0;
            rsx_reg        <= '0;
            span_reg       <= '0;
            rsy_reg        <= '0;
            line_h_reg     <= '0;
            x0_reg         <= '0;
            x1_reg         <= '0;
            y0_reg         <= '0;
            dbl_reg        <= 1'b0;
            pal_reg        <= 1'b0;
            rgb_reg        <= '0;
            il_reg         <= '0;
            il_test_reg    <= '0;
        end
        else
        begin
            disabled_reg   <= disabled_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            mode_w_reg     <= mode_w_next;
            mode_h_reg     <= mode_h_next;
            new_mode_w_reg <= new_mode_w_next;
            new_mode_h_reg <= new_mode_h_next;
            neg_adj_reg    <= neg_adj_next;
            rsx_reg        <= rsx_next;
            span_reg       <= span_next;
            rsy_reg        <= rsy_next;
            line_h_reg     <= line_h_next;
            x0_reg         <= x0_next;
            x1_reg         <= x1_next;
            y0_reg         <= y0_next;
            dbl_reg        <= dbl_next;
            pal_reg        <= pal_next;
            rgb_reg        <= rgb_next;
            il_reg         <= il_next;
            il_test_reg    <= il_test_next;
        end
    end

endmodule

/* sv/gpu_display_control_port.sv */
// Display-control port: each 32-bit control transaction on the slave side yields
// exactly one result transaction on the master side with the updated display
// position, size, centering offsets, mode flags and the geometry-changed and
// frame-update pulses. One transaction is taken per clock; each passes the input
// register, then the result register after one pass of decode and centering
// logic, which holds the 11x13 width-times-range multiply and the constant
// divide. Throughput stalls only while the result register is held by
// m_tready low. The swap-position control bit may be written on cfg at any time
// the port is idle.
module gpu_display_control_port (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [gdcp_pkg::IN_W-1:0] s_tdata,   // [31:0] command_word
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // start_x[9:0], start_y[18:10], width[28:19], height[41:29],
    // left_offset[51:42], visible_width[63:52], top_offset[74:64], disabled[75],
    // true_color[76], interlaced[77], geometry_changed[78], frame_update[79]
    output logic [gdcp_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data    // swap_position_fix
);

    logic                  in_valid_reg;
    logic [31:0]           word_reg;
    logic                  out_valid_reg;
    gdcp_pkg::res_t        res_reg;
    gdcp_pkg::res_t        res_next;
    logic                  swap_fix_reg;
    logic                  adv;

    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = res_reg;
    assign cfg_ready = 1'b1;

    gdcp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (adv),
        .word     (word_reg),
        .swap_fix (swap_fix_reg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            swap_fix_reg  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                swap_fix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* sv/gdcp_checker.sv */
`include "assert_macros.svh"

module gdcp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [gdcp_pkg::OUT_W-1:0] m_tdata
);

    // stalled result transaction holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // frame update only comes with a geometry change
    `ASSERT_CLK(a_frame_geo, m_tvalid && m_tdata[79] |-> m_tdata[78])
    // empty result register never blocks the slave side
    `ASSERT_CLK(a_ready_free, !m_tvalid |-> s_tready)
    // no result while in reset
    `ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !m_tvalid)

endmodule

bind gpu_display_control_port gdcp_checker u_gdcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
